FILE: sv/hermitian_bsr_sparse_dense_multiply_top_defines.svh
// assertion macros for the multiply block
`ifndef HERMITIAN_BSR_SPARSE_DENSE_MULTIPLY_TOP_DEFINES_SVH
`define HERMITIAN_BSR_SPARSE_DENSE_MULTIPLY_TOP_DEFINES_SVH

`define HBSR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define HBSR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/hbsr_pkg.sv
package hbsr_pkg;

  localparam int MAX_BLOCK_ROWS    = 64;
  localparam int MAX_STORED_BLOCKS = 256;
  localparam int MAX_BLOCK_EDGE    = 4;
  localparam int MAX_DENSE_WIDTH   = 8;

  localparam int ENT_PER_BLK = MAX_BLOCK_EDGE * MAX_BLOCK_EDGE;
  localparam int DENSE_DEPTH = MAX_BLOCK_ROWS * MAX_BLOCK_EDGE * MAX_DENSE_WIDTH;
  localparam int BR_AW  = $clog2(MAX_BLOCK_ROWS);
  localparam int SB_AW  = $clog2(MAX_STORED_BLOCKS);
  localparam int ENT_AW = $clog2(MAX_STORED_BLOCKS * ENT_PER_BLK);
  localparam int DN_AW  = $clog2(DENSE_DEPTH);
  localparam int OFF_W  = $clog2(ENT_PER_BLK);
  localparam int DW_W   = $clog2(MAX_DENSE_WIDTH);
  localparam int EDGE_W = $clog2(MAX_BLOCK_EDGE);

  localparam logic [2:0] CMD_PTR   = 3'd0;
  localparam logic [2:0] CMD_BCOL  = 3'd1;
  localparam logic [2:0] CMD_ENTRY = 3'd2;
  localparam logic [2:0] CMD_X     = 3'd3;
  localparam logic [2:0] CMD_Y     = 3'd4;
  localparam logic [2:0] CMD_START = 3'd5;
  localparam logic [2:0] CMD_READ  = 3'd6;

  localparam logic [2:0] REG_ALPHA_RE = 3'd0;
  localparam logic [2:0] REG_ALPHA_IM = 3'd1;
  localparam logic [2:0] REG_BETA_RE  = 3'd2;
  localparam logic [2:0] REG_BETA_IM  = 3'd3;
  localparam logic [2:0] REG_EDGE     = 3'd4;
  localparam logic [2:0] REG_BRC      = 3'd5;
  localparam logic [2:0] REG_DW       = 3'd6;
  localparam logic [2:0] REG_ORDER    = 3'd7;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  slot;
    logic [8:0]  ptr_begin;
    logic [8:0]  ptr_end;
    logic [5:0]  block_column;
    logic [3:0]  entry_offset;
    logic [7:0]  row_number;
    logic [2:0]  column_number;
    logic signed [31:0] value_real;
    logic signed [31:0] value_imag;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic signed [31:0] result_real;
    logic signed [31:0] result_imag;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] data;
  } cfg_item_t;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } cq_t;

  // complex multiply-accumulate unit opcodes
  typedef enum logic [1:0] {
    MU_MUL,     // r = a*b
    MU_MAC      // r = sat(c + a*b)
  } mu_op_t;

  typedef struct packed {
    logic   go;
    mu_op_t op;
    cq_t    a;
    cq_t    b;
    cq_t    c;
  } mu_req_t;

  typedef struct packed {
    logic done;
    cq_t  r;
  } mu_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RESP,
    S_READ_WAIT,
    S_INIT_RD,
    S_INIT_WAIT,
    S_INIT_BY,
    S_INIT_AX,
    S_INIT_WR,
    S_ROW_RD,
    S_ROW_WAIT,
    S_BLK_RD,
    S_BLK_WAIT,
    S_ENT_RD,
    S_ENT_WAIT,
    S_TERM_ORIG,
    S_TERM_CONJ,
    S_COL_RD,
    S_COL_WAIT,
    S_UPD_I,
    S_UPD_I_WR,
    S_UPD_J_RD,
    S_UPD_J_WAIT,
    S_UPD_J,
    S_UPD_J_WR
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

FILE: sv/hbsr_if.sv
interface hbsr_in_if;
  import hbsr_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hbsr_out_if;
  import hbsr_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hbsr_cfg_if;
  import hbsr_pkg::*;
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/hermitian_bsr_sparse_dense_multiply_top.sv
// loads and rejected items are answered from S_RESP, reads of y from S_READ_WAIT; one transaction in flight
// the next item is taken at the edge its result leaves
// start runs a scaling pass over every dense element, then a walk over each used entry
// and every dense column, through the shared complex multiplier
// synchronous active-low reset sets configuration to defaults and clears control; stores are
// undefined until written and need no clearing pass
module hermitian_bsr_sparse_dense_multiply_top (
  input logic clk,
  input logic rst_n,
  hbsr_in_if.sink    in_ch,
  hbsr_out_if.source out_ch,
  hbsr_cfg_if.sink   cfg_ch
);
  import hbsr_pkg::*;
  `include "hermitian_bsr_sparse_dense_multiply_top_defines.svh"

  logic signed [31:0] alpha_re_r, alpha_im_r, beta_re_r, beta_im_r;
  logic [2:0] edge_r;
  logic [6:0] brc_r;
  logic [3:0] dw_r;
  logic       order_r;

  state_t     st_r, st_nxt;
  in_item_t   item_r;
  out_item_t  out_r;
  logic       out_v_r;

  logic in_fire, cfg_fire, cfg_ok;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (st_r == S_IDLE) && (!out_v_r || out_ch.ready);
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  assign cfg_ok = edge_r >= 3'd1 && edge_r <= 3'(MAX_BLOCK_EDGE)
               && brc_r >= 7'd1 && brc_r <= 7'(MAX_BLOCK_ROWS)
               && dw_r >= 4'd1 && dw_r <= 4'(MAX_DENSE_WIDTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_re_r <= 32'sd65536;
      alpha_im_r <= '0;
      beta_re_r  <= '0;
      beta_im_r  <= '0;
      edge_r     <= 3'd1;
      brc_r      <= 7'd1;
      dw_r       <= 4'd1;
      order_r    <= 1'b0;
    end else if (cfg_fire) begin
      case (cfg_ch.data.index)
        REG_ALPHA_RE: alpha_re_r <= cfg_ch.data.data;
        REG_ALPHA_IM: alpha_im_r <= cfg_ch.data.data;
        REG_BETA_RE:  beta_re_r  <= cfg_ch.data.data;
        REG_BETA_IM:  beta_im_r  <= cfg_ch.data.data;
        REG_EDGE:     edge_r     <= cfg_ch.data.data[2:0];
        REG_BRC:      brc_r      <= cfg_ch.data.data[6:0];
        REG_DW:       dw_r       <= cfg_ch.data.data[3:0];
        REG_ORDER:    order_r    <= cfg_ch.data.data[0];
        default: ;
      endcase
    end
  end

  // sizes
  logic [8:0] m_rows;
  logic [4:0] bs2;
  assign m_rows = 9'(brc_r) * 9'(edge_r);
  assign bs2    = 5'(edge_r) * 5'(edge_r);

  // command checks on the held item
  logic pos_ok;
  always_comb begin
    pos_ok = 1'b0;
    case (item_r.command)
      CMD_PTR:   pos_ok = 9'(item_r.slot) < 9'(brc_r);
      CMD_BCOL:  pos_ok = 10'(item_r.slot) < 10'(MAX_STORED_BLOCKS);
      CMD_ENTRY: pos_ok = 10'(item_r.slot) < 10'(MAX_STORED_BLOCKS)
                          && 5'(item_r.entry_offset) < bs2;
      CMD_X, CMD_Y, CMD_READ:
                 pos_ok = 9'(item_r.row_number) < m_rows
                          && 4'(item_r.column_number) < dw_r;
      CMD_START: pos_ok = 1'b1;
      default:   pos_ok = 1'b0;
    endcase
  end

  // memories
  logic            ptr_we;
  logic [BR_AW-1:0] ptr_ra;
  logic [17:0]     ptr_rd;
  logic            bc_we;
  logic [SB_AW-1:0] bc_ra;
  logic [5:0]      bc_rd;
  logic            ent_we;
  logic [ENT_AW-1:0] ent_wa, ent_ra;
  logic [63:0]     ent_rd;
  logic            x_we, y_we;
  logic [DN_AW-1:0] x_ra, y_ra, y_wa, dn_wa;
  logic [63:0]     x_rd, y_rd, y_wd;

  assign dn_wa = DN_AW'({item_r.row_number, item_r.column_number});

  hbsr_ram #(.WIDTH(18), .DEPTH(MAX_BLOCK_ROWS)) u_ptr (
    .clk, .we(ptr_we), .waddr(item_r.slot[BR_AW-1:0]),
    .wdata({item_r.ptr_begin, item_r.ptr_end}), .raddr(ptr_ra), .rdata(ptr_rd));
  hbsr_ram #(.WIDTH(6), .DEPTH(MAX_STORED_BLOCKS)) u_bcol (
    .clk, .we(bc_we), .waddr(item_r.slot[SB_AW-1:0]),
    .wdata(item_r.block_column), .raddr(bc_ra), .rdata(bc_rd));
  hbsr_ram #(.WIDTH(64), .DEPTH(MAX_STORED_BLOCKS * ENT_PER_BLK)) u_ent (
    .clk, .we(ent_we), .waddr(ent_wa),
    .wdata({item_r.value_real, item_r.value_imag}), .raddr(ent_ra), .rdata(ent_rd));
  hbsr_ram #(.WIDTH(64), .DEPTH(DENSE_DEPTH)) u_x (
    .clk, .we(x_we), .waddr(dn_wa),
    .wdata({item_r.value_real, item_r.value_imag}), .raddr(x_ra), .rdata(x_rd));
  hbsr_ram #(.WIDTH(64), .DEPTH(DENSE_DEPTH)) u_y (
    .clk, .we(y_we), .waddr(y_wa), .wdata(y_wd), .raddr(y_ra), .rdata(y_rd));

  assign ent_wa = ENT_AW'({item_r.slot, item_r.entry_offset});

  // walk counters
  logic [8:0]  row_r, row_nxt;       // dense row in the scaling pass
  logic [DW_W:0] col_r, col_nxt;     // dense column
  logic [6:0]  br_r, br_nxt;
  logic [9:0]  ai_r, ai_nxt, last_r, last_nxt;
  logic [5:0]  bcol_r, bcol_nxt;
  logic [EDGE_W:0] p_r, p_nxt, q_r, q_nxt;
  cq_t         t_orig_r, t_orig_nxt, t_conj_r, t_conj_nxt, ent_r, ent_nxt;
  cq_t         tmp_r, tmp_nxt, xi_r, xi_nxt;
  logic [8:0]  gi_r, gi_nxt, gj_r, gj_nxt;

  mu_req_t mu_req;
  mu_rsp_t mu_rsp;
  hbsr_cmul u_mu (.clk, .rst_n, .req(mu_req), .rsp(mu_rsp));

  // element row and column inside block from walk indices
  logic [EDGE_W:0] er, ec;
  assign er = order_r ? q_r : p_r;
  assign ec = order_r ? p_r : q_r;
  logic [OFF_W-1:0] eoff;
  assign eoff = order_r ? OFF_W'(5'(ec) * 5'(edge_r) + 5'(er))
                        : OFF_W'(5'(er) * 5'(edge_r) + 5'(ec));
  logic ent_used;
  assign ent_used = !(bcol_r == 6'(br_r) && ec <= er);

  logic [EDGE_W:0] edge_n;
  assign edge_n = (EDGE_W + 1)'(edge_r);

  logic [DN_AW-1:0] gi_addr, gj_addr;
  assign gi_addr = DN_AW'({gi_r, col_r[DW_W-1:0]});
  assign gj_addr = DN_AW'({gj_r, col_r[DW_W-1:0]});

  cq_t ent_neg;
  assign ent_neg.re = ent_r.re;
  assign ent_neg.im = sat32(-34'(ent_r.im));

  cq_t alpha_c, beta_c;
  assign alpha_c = '{re: alpha_re_r, im: alpha_im_r};
  assign beta_c  = '{re: beta_re_r, im: beta_im_r};

  // next step of the block-entry walk
  logic [EDGE_W:0] q_inc, p_inc;
  assign q_inc = q_r + 1'b1;
  assign p_inc = p_r + 1'b1;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:      st_nxt = in_fire ? S_RESP : S_IDLE;
      S_RESP: begin
        if (cfg_ok && pos_ok && item_r.command == CMD_START) begin
          st_nxt = S_INIT_RD;
        end else if (cfg_ok && pos_ok && item_r.command == CMD_READ) begin
          st_nxt = S_READ_WAIT;
        end else begin
          st_nxt = S_IDLE;
        end
      end
      S_READ_WAIT: st_nxt = S_IDLE;
      S_INIT_RD:   st_nxt = S_INIT_WAIT;
      S_INIT_WAIT: st_nxt = S_INIT_BY;
      S_INIT_BY:   st_nxt = mu_rsp.done ? S_INIT_AX : S_INIT_BY;
      S_INIT_AX:   st_nxt = mu_rsp.done ? S_INIT_WR : S_INIT_AX;
      S_INIT_WR: begin
        if (4'(col_r) + 4'd1 < dw_r || row_r + 9'd1 < m_rows) begin
          st_nxt = S_INIT_RD;
        end else begin
          st_nxt = S_ROW_RD;
        end
      end
      S_ROW_RD:    st_nxt = S_ROW_WAIT;
      S_ROW_WAIT:  st_nxt = S_BLK_RD;
      S_BLK_RD: begin
        if (ai_r >= last_r) begin
          st_nxt = (br_r + 7'd1 < brc_r) ? S_ROW_RD : S_IDLE;
        end else begin
          st_nxt = S_BLK_WAIT;
        end
      end
      S_BLK_WAIT: begin
        st_nxt = (bc_rd < 6'(br_r) || 7'(bc_rd) >= brc_r) ? S_BLK_RD : S_ENT_RD;
      end
      S_ENT_RD: begin
        if (!ent_used) begin
          if (q_inc < edge_n || p_inc < edge_n) begin
            st_nxt = S_ENT_RD;
          end else begin
            st_nxt = S_BLK_RD;
          end
        end else begin
          st_nxt = S_ENT_WAIT;
        end
      end
      S_ENT_WAIT:  st_nxt = S_TERM_ORIG;
      S_TERM_ORIG: st_nxt = mu_rsp.done ? S_TERM_CONJ : S_TERM_ORIG;
      S_TERM_CONJ: st_nxt = mu_rsp.done ? S_COL_RD : S_TERM_CONJ;
      S_COL_RD:    st_nxt = S_COL_WAIT;
      S_COL_WAIT:  st_nxt = S_UPD_I;
      S_UPD_I:     st_nxt = mu_rsp.done ? S_UPD_I_WR : S_UPD_I;
      S_UPD_I_WR:  st_nxt = S_UPD_J_RD;
      S_UPD_J_RD:  st_nxt = S_UPD_J_WAIT;
      S_UPD_J_WAIT: st_nxt = S_UPD_J;
      S_UPD_J:     st_nxt = mu_rsp.done ? S_UPD_J_WR : S_UPD_J;
      S_UPD_J_WR: begin
        if (4'(col_r) + 4'd1 < dw_r) begin
          st_nxt = S_COL_RD;
        end else if (q_inc < edge_n || p_inc < edge_n) begin
          st_nxt = S_ENT_RD;
        end else begin
          st_nxt = S_BLK_RD;
        end
      end
      default:     st_nxt = S_IDLE;
    endcase
  end

  // a request is issued in the wait state before a multiply, or when the previous multiply is done
  logic mu_first_r;
  always_comb begin
    mu_req    = '0;
    mu_req.op = MU_MUL;
    ptr_we = 1'b0; bc_we = 1'b0; ent_we = 1'b0; x_we = 1'b0; y_we = 1'b0;
    ptr_ra = br_r[BR_AW-1:0];
    bc_ra  = ai_r[SB_AW-1:0];
    ent_ra = ENT_AW'({ai_r[SB_AW-1:0], eoff});
    x_ra   = gi_addr;
    y_ra   = gi_addr;
    y_wa   = gi_addr;
    y_wd   = tmp_r;
    row_nxt = row_r; col_nxt = col_r; br_nxt = br_r; ai_nxt = ai_r;
    last_nxt = last_r; bcol_nxt = bcol_r; p_nxt = p_r; q_nxt = q_r;
    t_orig_nxt = t_orig_r; t_conj_nxt = t_conj_r; ent_nxt = ent_r;
    tmp_nxt = tmp_r; xi_nxt = xi_r; gi_nxt = gi_r; gj_nxt = gj_r;
    case (st_r)
      S_IDLE: begin
        y_ra = DN_AW'({in_ch.data.row_number, in_ch.data.column_number});
      end
      S_RESP: begin
        y_ra = dn_wa;
        if (cfg_ok && pos_ok) begin
          ptr_we = item_r.command == CMD_PTR;
          bc_we  = item_r.command == CMD_BCOL;
          ent_we = item_r.command == CMD_ENTRY;
          x_we   = item_r.command == CMD_X;
          y_we   = item_r.command == CMD_Y;
          y_wa   = dn_wa;
          y_wd   = {item_r.value_real, item_r.value_imag};
        end
        row_nxt = '0; col_nxt = '0; br_nxt = '0; gi_nxt = '0;
      end
      S_INIT_RD: begin
      end
      S_INIT_WAIT: begin
        mu_req = '{go: 1'b1, op: MU_MUL, a: beta_c, b: y_rd, c: '0};
        xi_nxt = x_rd;
      end
      S_INIT_BY: begin
        if (mu_rsp.done) begin
          mu_req = '{go: 1'b1, op: MU_MAC, a: alpha_c, b: xi_r, c: mu_rsp.r};
        end
      end
      S_INIT_AX: begin
        if (mu_rsp.done) tmp_nxt = mu_rsp.r;
      end
      S_INIT_WR: begin
        y_we = 1'b1;
        if (4'(col_r) + 4'd1 < dw_r) begin
          col_nxt = col_r + 1'b1;
        end else begin
          col_nxt = '0;
          row_nxt = row_r + 9'd1;
          gi_nxt  = row_r + 9'd1;
        end
      end
      S_ROW_RD: begin
      end
      S_ROW_WAIT: begin
        ai_nxt   = 10'(ptr_rd[17:9]);
        last_nxt = (ptr_rd[8:0] > 9'(MAX_STORED_BLOCKS)) ? 10'(MAX_STORED_BLOCKS)
                                                       : 10'(ptr_rd[8:0]);
      end
      S_BLK_RD: begin
        if (ai_r >= last_r) begin
          br_nxt = br_r + 7'd1;
          ptr_ra = BR_AW'(br_r + 7'd1);
        end
        p_nxt = '0; q_nxt = '0;
      end
      S_BLK_WAIT: begin
        bcol_nxt = bc_rd;
        if (bc_rd < 6'(br_r) || 7'(bc_rd) >= brc_r) ai_nxt = ai_r + 10'd1;
      end
      S_ENT_RD: begin
        gi_nxt = 9'(br_r) * 9'(edge_r) + 9'(er);
        gj_nxt = 9'(bcol_r) * 9'(edge_r) + 9'(ec);
        col_nxt = '0;
        if (!ent_used) begin
          if (q_inc < edge_n) begin
            q_nxt = q_inc;
          end else begin
            q_nxt = '0;
            p_nxt = p_inc;
            if (!(p_inc < edge_n)) ai_nxt = ai_r + 10'd1;
          end
        end
      end
      S_ENT_WAIT: begin
        ent_nxt = ent_rd;
        mu_req = '{go: 1'b1, op: MU_MUL, a: alpha_c, b: cq_t'(ent_rd), c: '0};
      end
      S_TERM_ORIG: begin
        if (mu_rsp.done) begin
          t_orig_nxt = mu_rsp.r;
          mu_req = '{go: 1'b1, op: MU_MUL, a: alpha_c, b: ent_neg, c: '0};
        end
      end
      S_TERM_CONJ: begin
        if (mu_rsp.done) t_conj_nxt = mu_rsp.r;
      end
      S_COL_RD: begin
        x_ra = gj_addr;
        y_ra = gi_addr;
      end
      S_COL_WAIT: begin
        mu_req = '{go: 1'b1, op: MU_MAC, a: t_conj_r, b: x_rd, c: y_rd};
      end
      S_UPD_I: begin
        if (mu_rsp.done) tmp_nxt = mu_rsp.r;
      end
      S_UPD_I_WR: begin
        y_we = 1'b1;
        y_wa = gi_addr;
      end
      S_UPD_J_RD: begin
        x_ra = gi_addr;
        y_ra = gj_addr;
      end
      S_UPD_J_WAIT: begin
        mu_req = '{go: 1'b1, op: MU_MAC, a: t_orig_r, b: x_rd, c: y_rd};
      end
      S_UPD_J: begin
        if (mu_rsp.done) tmp_nxt = mu_rsp.r;
      end
      S_UPD_J_WR: begin
        y_we = 1'b1;
        y_wa = gj_addr;
        if (4'(col_r) + 4'd1 < dw_r) begin
          col_nxt = col_r + 1'b1;
        end else begin
          col_nxt = '0;
          if (q_inc < edge_n) begin
            q_nxt = q_inc;
          end else begin
            q_nxt = '0;
            p_nxt = p_inc;
            if (!(p_inc < edge_n)) ai_nxt = ai_r + 10'd1;
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  logic      out_set;
  out_item_t out_nxt;
  always_comb begin
    out_set = 1'b0;
    out_nxt = '0;
    out_nxt.status = 1'b0;
    if (st_r == S_RESP) begin
      if (!(cfg_ok && pos_ok)) begin
        out_set = 1'b1;
        out_nxt.status = 1'b1;
      end else if (item_r.command == CMD_START || item_r.command == CMD_READ) begin
        out_set = 1'b0;
      end else begin
        out_set = 1'b1;
      end
    end else if (st_r == S_READ_WAIT) begin
      out_set = 1'b1;
      out_nxt.result_real = y_rd[63:32];
      out_nxt.result_imag = y_rd[31:0];
    end else if (st_r == S_BLK_RD && ai_r >= last_r && !(br_r + 7'd1 < brc_r)) begin
      out_set = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      out_v_r    <= 1'b0;
      mu_first_r <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      mu_first_r <= mu_req.go;
      if (out_set) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
    if (out_set) out_r <= out_nxt;
    if (in_fire) item_r <= in_ch.data;
    row_r <= row_nxt; col_r <= col_nxt; br_r <= br_nxt; ai_r <= ai_nxt;
    last_r <= last_nxt; bcol_r <= bcol_nxt; p_r <= p_nxt; q_r <= q_nxt;
    t_orig_r <= t_orig_nxt; t_conj_r <= t_conj_nxt; ent_r <= ent_nxt;
    tmp_r <= tmp_nxt; xi_r <= xi_nxt; gi_r <= gi_nxt; gj_r <= gj_nxt;
  end

  `HBSR_ASSERT_IMP(a_no_accept_busy, clk, rst_n, st_r != S_IDLE, !in_ch.ready,
                   "input accepted while busy")
  `HBSR_ASSERT_IMP(a_one_mul, clk, rst_n, mu_first_r, !mu_req.go,
                   "multiplier restarted back to back")
  `HBSR_ASSERT_NXT(a_out_after_item, clk, rst_n, in_fire, !out_v_r,
                   "result pending when item accepted")
endmodule

FILE: sv/hbsr_ram.sv
module hbsr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/hbsr_cmul.sv
module hbsr_cmul (
  input  logic               clk,
  input  logic               rst_n,
  input  hbsr_pkg::mu_req_t  req,
  output hbsr_pkg::mu_rsp_t  rsp
);
  import hbsr_pkg::*;

  // one 32x32 product per cycle for the four partial products, then round and add
  logic [2:0]         step_r, step_nxt;
  mu_req_t            req_r, req_nxt;
  logic signed [63:0] prod_r;
  logic signed [63:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic signed [31:0] m_a, m_b;
  logic               busy_r, busy_nxt;
  logic signed [31:0] re_q, im_q;
  cq_t                res;

  function automatic logic signed [31:0] rnd_pair(input logic signed [63:0] p1,
                                                 input logic signed [63:0] p2);
    logic signed [65:0] s;
    logic signed [49:0] h;
    s = 66'(p1) + 66'(p2) + 66'sd32768;
    h = s[65:16];
    if (h > 50'sd2147483647) return 32'sh7fffffff;
    if (h < -50'sd2147483648) return 32'sh80000000;
    return h[31:0];
  endfunction

  always_comb begin
    case (step_r)
      3'd0:    begin m_a = req_r.a.re; m_b = req_r.b.re; end
      3'd1:    begin m_a = req_r.a.im; m_b = req_r.b.im; end
      3'd2:    begin m_a = req_r.a.re; m_b = req_r.b.im; end
      default: begin m_a = req_r.a.im; m_b = req_r.b.re; end
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    req_nxt  = req_r;
    if (req.go) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      req_nxt  = req;
    end else if (busy_r) begin
      step_nxt = step_r + 3'd1;
      if (step_r == 3'd4) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    req_r  <= req_nxt;
    prod_r <= m_a * m_b;
    if (busy_r) begin
      case (step_r)
        3'd1:    p_rr_r <= prod_r;
        3'd2:    p_ii_r <= prod_r;
        3'd3:    p_ri_r <= prod_r;
        default: p_ir_r <= prod_r;
      endcase
    end
  end

  assign re_q = rnd_pair(p_rr_r, -p_ii_r);
  assign im_q = rnd_pair(p_ri_r, p_ir_r);

  always_comb begin
    if (req_r.op == MU_MAC) begin
      res.re = sat32(34'(req_r.c.re) + 34'(re_q));
      res.im = sat32(34'(req_r.c.im) + 34'(im_q));
    end else begin
      res.re = re_q;
      res.im = im_q;
    end
  end

  // result and done are valid together, once the last product is registered
  logic done_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && step_r == 3'd4 && !req.go;
    end
  end

  assign rsp.done = done_r;
  assign rsp.r    = res;
endmodule
